@@ src/hybla_cwnd_update_core_defines.svh @@
// assertion macros for the hybla window update core
`ifndef HYBLA_CWND_UPDATE_CORE_DEFINES_SVH
`define HYBLA_CWND_UPDATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hybla core check failed");
`define HCU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hybla core check failed");
`else
`define HCU_ASSERT_IMP(lbl, ante, cons)
`define HCU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/hcu_pkg.sv @@
// types, constants and tables shared by the hybla window update core
package hcu_pkg;
	localparam int DIV_W = 48;
	localparam int DIV_CNT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INFLIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RTO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_RTT = 2'd3;

	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [15:0] HALF_Q15 = 16'd16384;
	localparam logic [15:0] GAP_FACTOR_Q15 = 16'd29491;
	localparam logic [12:0] RHO_ONE = 13'd256;
	localparam logic [12:0] RHO_MAX = 13'd4096;

	// ceil(2^34 / 1000), exact us to ms for any 24-bit value
	localparam logic [31:0] RECIP_1000 = 32'd17179870;

	typedef enum logic [5:0] {
		ST_IDLE, ST_SR_M1, ST_SR_M2, ST_SR_M3,
		ST_RHO_D1, ST_RHO_W1, ST_RHO_D2, ST_RHO_W2,
		ST_SC_D1, ST_SC_W1, ST_SC_D2, ST_SC_W2, ST_SC_M1, ST_SC_M2, ST_SC_M3,
		ST_SC_D3, ST_SC_W3, ST_SC_D4, ST_SC_W4, ST_SC_M4, ST_SC_M5, ST_SC_M6,
		ST_SS_CHK, ST_PW_M, ST_PW_A, ST_SS_PW, ST_SS_M1, ST_SS_M2, ST_SS_M3,
		ST_AV_CHK, ST_AV_M1, ST_AV_D, ST_AV_W, ST_AV_M2, ST_AV_A, ST_AV_P,
		ST_AV_M3, ST_AV_M4, ST_DONE
	} st_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
		logic [DIV_CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// 2^(2^(i-8)) in Q2.30
	function automatic logic [31:0] frac_pow_q30(input logic [2:0] i);
		logic [31:0] v;
		case (i)
			3'd0: v = 32'd1076653033;
			3'd1: v = 32'd1079572136;
			3'd2: v = 32'd1085434106;
			3'd3: v = 32'd1097253708;
			3'd4: v = 32'd1121280436;
			3'd5: v = 32'd1170923762;
			3'd6: v = 32'd1276901417;
			3'd7: v = 32'd1518500250;
			default: v = 32'd1073741824;
		endcase
		return v;
	endfunction
endpackage

@@ src/hcu_ifs.sv @@
// valid/ready channels for ack words and result words
interface hcu_ack_if;
	logic valid;
	logic ready;
	logic [23:0] rtt_sample_us;
	logic [23:0] min_rtt_us;
	logic [15:0] segments_acked;
	logic [31:0] cwnd_bytes;
	logic [31:0] ssthresh_bytes;
	logic [31:0] inflight_bytes;
	logic [23:0] stack_srtt_us;
	logic [31:0] next_tx_seq;
	logic [31:0] last_acked_seq;
	logic [15:0] segment_bytes;
	modport source (output valid, rtt_sample_us, min_rtt_us, segments_acked, cwnd_bytes,
		ssthresh_bytes, inflight_bytes, stack_srtt_us, next_tx_seq, last_acked_seq,
		segment_bytes, input ready);
	modport sink (input valid, rtt_sample_us, min_rtt_us, segments_acked, cwnd_bytes,
		ssthresh_bytes, inflight_bytes, stack_srtt_us, next_tx_seq, last_acked_seq,
		segment_bytes, output ready);
endinterface

interface hcu_result_if;
	logic valid;
	logic ready;
	logic [31:0] new_cwnd_bytes;
	logic [15:0] growth_scale;
	logic in_slow_start;
	modport source (output valid, new_cwnd_bytes, growth_scale, in_slow_start, input ready);
	modport sink (input valid, new_cwnd_bytes, growth_scale, in_slow_start, output ready);
endinterface

@@ src/hybla_cwnd_update_core.sv @@
// hybla congestion window update core: sequencer and datapath
// Usage: one ack word enters on the ack channel (valid/ready), one result word
// leaves on the result channel. ack.ready is high only while the core is idle;
// each word is worked on alone by a sequencer that drives one shared 32x32
// multiplier and one shared radix-2 divider.
// The divider produces one quotient bit per cycle, up to 47 bits, and a word
// needs up to ten divisions (rho ratio, two passes of the scale factor,
// avoidance increment). The 2^rho product is built on the multiplier from
// the fractional bits of rho, then shifted by its integer part.
// The core takes no new word until it has finished the last one; a new word is
// taken while the previous result still waits in the output register.
// If the receiver stalls with a result pending, the next word is still
// computed and then held until the output register frees.
// Reset (arst_n low) sets the registers to their defaults, smoothed RTT to
// zero, rho to 1.0 and the window fraction to zero; configuration writes land
// at any cycle through cfg_write_en, cfg_index and cfg_data.
`include "hybla_cwnd_update_core_defines.svh"
module hybla_cwnd_update_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_en,
	input logic [hcu_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hcu_pkg::CFG_DATA_W-1:0] cfg_data,
	hcu_ack_if.sink ack,
	hcu_result_if.source result
);
	import hcu_pkg::*;

	st_t state_q, state_d;

	logic [8:0] w_q;
	logic [9:0] ithr_q;
	logic [11:0] rw_q;
	logic [13:0] ref_q;

	logic [23:0] s_q;
	logic [12:0] rho_q;
	logic [31:0] frac_q;

	logic [23:0] rtt_q, minrtt_q, ssrtt_q;
	logic [15:0] segs_q, seg_q;
	logic [31:0] cwnd_q, cwnd_in_q, ssth_q, infl_q, gap_q;
	logic [43:0] tmp_q;
	logic [14:0] ms_q;
	logic [39:0] d_q;
	logic [44:0] denom_q;
	logic [15:0] fin_q, frto_q, scale1_q, scale2_q;
	logic [31:0] cs_q, p_q, acc_q;
	logic gap_hit_q, slow_q, payout_q, pass_q;
	logic [2:0] pi_q;

	logic out_valid_q, out_slow_q;
	logic [31:0] out_cwnd_q;
	logic [15:0] out_scale_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	div_req_t div_req;
	div_stat_t div_stat;
	logic [DIV_W-1:0] div_q;

	hcu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
	hcu_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .stat(div_stat),
		.quotient(div_q));

	logic accept, out_free, out_load, div_done;
	logic [8:0] w_eff;
	logic [13:0] ref_eff;
	logic [23:0] eff_rtt;
	st_t after_sr;

	assign accept = ack.valid && ack.ready;
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign div_done = div_stat.done;
	assign w_eff = (w_q > 9'd256) ? 9'd256 : w_q;
	assign ref_eff = (ref_q == 14'd0) ? 14'd1 : ref_q;
	assign eff_rtt = (s_q != 24'd0) ? s_q : minrtt_q;
	assign after_sr = (rtt_q == minrtt_q) ? ST_RHO_D1 : ST_SC_D1;

	// datapath terms
	logic [34:0] sr_sum;
	logic [12:0] rho_new;
	logic [DIV_W-1:0] ratio, thr, drop, rr_raw;
	logic [15:0] fin_next;
	logic [39:0] d_next;
	logic [51:0] sc_sum;
	logic [44:0] denom_next;
	logic [15:0] f_fl;
	logic [33:0] pw, pwm;
	logic [32:0] ss_sum, av_sum;
	logic [40:0] acc_full;
	logic [31:0] acc_sat, cs_eff;
	logic [7:0] rho_lo;

	always_comb begin
		sr_sum = {1'b0, tmp_q[33:0]} + {1'b0, prod[33:0]};
		if (div_q < DIV_W'(RHO_ONE))
			rho_new = RHO_ONE;
		else if (div_q > DIV_W'(RHO_MAX))
			rho_new = RHO_MAX;
		else
			rho_new = div_q[12:0];
		ratio = (cwnd_q == 32'd0) ? '0 : div_q;
		thr = {31'b0, ithr_q, 7'b0};
		drop = (ratio - thr) >> 1;
		if (ratio > thr) begin
			fin_next = (drop >= DIV_W'(HALF_Q15)) ? HALF_Q15 : ONE_Q15 - drop[15:0];
		end else begin
			fin_next = ONE_Q15;
		end
		rr_raw = (s_q == 24'd0) ? DIV_W'(ONE_Q15) : div_q;
		d_next = (rr_raw < DIV_W'(ONE_Q15)) ? 40'd0 : 40'(rr_raw - DIV_W'(ONE_Q15));
		sc_sum = {8'b0, tmp_q} + {prod[19:0], 32'b0};
		denom_next = 45'(ONE_Q15) + {1'b0, sc_sum[51:8]};
		f_fl = (prod[30:15] < HALF_Q15) ? HALF_Q15 : prod[30:15];
		pw = {17'b0, p_q[30:14]} << rho_q[12:8];
		pwm = pw - 34'd65536;
		ss_sum = {1'b0, cwnd_q} + {1'b0, prod[47:16]};
		acc_full = {9'b0, frac_q} + prod[40:0];
		acc_sat = (acc_full[40:32] != 9'd0) ? 32'hFFFF_FFFF : acc_full[31:0];
		av_sum = {1'b0, cwnd_q} + {1'b0, prod[46:15]};
		cs_eff = (cs_q == 32'd0) ? 32'd1 : cs_q;
		rho_lo = rho_q[7:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (ack.valid) state_d = ST_SR_M1;
			ST_SR_M1: state_d = (s_q == 24'd0) ? after_sr : ST_SR_M2;
			ST_SR_M2: state_d = ST_SR_M3;
			ST_SR_M3: state_d = after_sr;
			ST_RHO_D1: state_d = ST_RHO_W1;
			ST_RHO_W1: state_d = ST_RHO_D2;
			ST_RHO_D2: state_d = ST_RHO_W2;
			ST_RHO_W2: if (div_done) state_d = ST_SC_D1;
			ST_SC_D1: state_d = ST_SC_W1;
			ST_SC_W1: if (div_done) state_d = ST_SC_D2;
			ST_SC_D2: state_d = ST_SC_W2;
			ST_SC_W2: if (div_done) state_d = ST_SC_M1;
			ST_SC_M1: state_d = ST_SC_M2;
			ST_SC_M2: state_d = ST_SC_M3;
			ST_SC_M3: state_d = ST_SC_D3;
			ST_SC_D3: state_d = ST_SC_W3;
			ST_SC_W3: if (div_done) state_d = ST_SC_D4;
			ST_SC_D4: state_d = ST_SC_W4;
			ST_SC_W4: if (div_done) state_d = ST_SC_M4;
			ST_SC_M4: state_d = ST_SC_M5;
			ST_SC_M5: state_d = ST_SC_M6;
			ST_SC_M6: state_d = pass_q ? ST_AV_M1 : ST_SS_CHK;
			ST_SS_CHK: state_d = (cwnd_q <= ssth_q && segs_q != 16'd0) ? ST_PW_M : ST_AV_CHK;
			ST_PW_M: state_d = ST_PW_A;
			ST_PW_A: state_d = (pi_q == 3'd7) ? ST_SS_PW : ST_PW_M;
			ST_SS_PW: state_d = ST_SS_M1;
			ST_SS_M1: state_d = ST_SS_M2;
			ST_SS_M2: state_d = ST_SS_M3;
			ST_SS_M3: state_d = ST_AV_CHK;
			ST_AV_CHK: begin
				if (cwnd_q >= ssth_q && segs_q != 16'd0)
					state_d = slow_q ? ST_SC_D1 : ST_AV_M1;
				else
					state_d = ST_DONE;
			end
			ST_AV_M1: state_d = ST_AV_D;
			ST_AV_D: state_d = ST_AV_W;
			ST_AV_W: if (div_done) state_d = ST_AV_M2;
			ST_AV_M2: state_d = ST_AV_A;
			ST_AV_A: state_d = ST_AV_P;
			ST_AV_P: state_d = (acc_q[31:16] != 16'd0) ? ST_AV_M3 : ST_DONE;
			ST_AV_M3: state_d = ST_AV_M4;
			ST_AV_M4: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		case (state_q)
			ST_SR_M1: begin
				mul_a = {8'b0, s_q};
				mul_b = {23'b0, w_eff};
			end
			ST_SR_M2: begin
				mul_a = {8'b0, rtt_q};
				mul_b = {23'b0, 9'd256 - w_eff};
			end
			// microseconds to milliseconds by reciprocal multiply
			ST_RHO_D1: begin
				mul_a = {8'b0, eff_rtt};
				mul_b = RECIP_1000;
			end
			ST_RHO_D2: begin
				div_req.start = 1'b1;
				div_req.dividend = {25'b0, ms_q, 8'b0};
				div_req.divisor = {34'b0, ref_eff};
				div_req.nbits = DIV_CNT_W'(23);
			end
			ST_SC_D1: begin
				div_req.start = 1'b1;
				div_req.dividend = {1'b0, infl_q, 15'b0};
				div_req.divisor = {16'b0, cwnd_q};
				div_req.nbits = DIV_CNT_W'(47);
			end
			ST_SC_D2: begin
				div_req.start = 1'b1;
				div_req.dividend = {8'b0, ssrtt_q, 16'b0};
				div_req.divisor = {24'b0, s_q};
				div_req.nbits = DIV_CNT_W'(40);
			end
			ST_SC_M1: begin
				mul_a = d_q[31:0];
				mul_b = {20'b0, rw_q};
			end
			ST_SC_M2: begin
				mul_a = {24'b0, d_q[39:32]};
				mul_b = {20'b0, rw_q};
			end
			ST_SC_D3: begin
				div_req.start = 1'b1;
				div_req.dividend = DIV_W'(32'h4000_0000);
				div_req.divisor = {3'b0, denom_q};
				div_req.nbits = DIV_CNT_W'(31);
			end
			ST_SC_D4: begin
				div_req.start = 1'b1;
				div_req.dividend = {16'b0, cwnd_q};
				div_req.divisor = {32'b0, seg_q};
				div_req.nbits = DIV_CNT_W'(32);
			end
			ST_SC_M4: begin
				mul_a = {16'b0, fin_q};
				mul_b = {16'b0, frto_q};
			end
			ST_SC_M5: begin
				mul_a = {16'b0, prod[30:15]};
				mul_b = {16'b0, gap_hit_q ? GAP_FACTOR_Q15 : ONE_Q15};
			end
			ST_PW_M: begin
				mul_a = p_q;
				mul_b = frac_pow_q30(pi_q);
			end
			ST_SS_M1: begin
				mul_a = tmp_q[31:0];
				mul_b = {16'b0, scale1_q};
			end
			ST_SS_M2: begin
				mul_a = prod[46:15];
				mul_b = {16'b0, seg_q};
			end
			ST_AV_M1: begin
				mul_a = {19'b0, rho_q};
				mul_b = {19'b0, rho_q};
			end
			ST_AV_D: begin
				div_req.start = 1'b1;
				div_req.dividend = {23'b0, prod[24:0]};
				div_req.divisor = {16'b0, cs_eff};
				div_req.nbits = DIV_CNT_W'(25);
			end
			ST_AV_M2: begin
				mul_a = tmp_q[31:0];
				mul_b = {16'b0, segs_q};
			end
			ST_AV_P: begin
				mul_a = {16'b0, acc_q[31:16]};
				mul_b = {16'b0, scale2_q};
			end
			ST_AV_M3: begin
				mul_a = prod[31:0];
				mul_b = {16'b0, seg_q};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign ack.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q <= 9'd230;
			ithr_q <= 10'd205;
			rw_q <= 12'd256;
			ref_q <= 14'd50;
			s_q <= '0;
			rho_q <= RHO_ONE;
			frac_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_SMOOTHING: w_q <= cfg_data[8:0];
					CFG_INFLIGHT: ithr_q <= cfg_data[9:0];
					CFG_RTO: rw_q <= cfg_data[11:0];
					CFG_REF_RTT: ref_q <= cfg_data[13:0];
					default: ref_q <= ref_q;
				endcase
			end
			if (state_q == ST_SR_M1 && s_q == 24'd0)
				s_q <= rtt_q;
			if (state_q == ST_SR_M3)
				s_q <= sr_sum[31:8];
			if (state_q == ST_RHO_W2 && div_done)
				rho_q <= rho_new;
			if (state_q == ST_AV_P && acc_q[31:16] == 16'd0)
				frac_q <= acc_q;
			if (state_q == ST_AV_M4)
				frac_q <= {16'b0, acc_q[15:0]};
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rtt_q <= ack.rtt_sample_us;
					minrtt_q <= ack.min_rtt_us;
					segs_q <= ack.segments_acked;
					cwnd_q <= ack.cwnd_bytes;
					cwnd_in_q <= ack.cwnd_bytes;
					ssth_q <= ack.ssthresh_bytes;
					infl_q <= ack.inflight_bytes;
					ssrtt_q <= ack.stack_srtt_us;
					gap_q <= ack.next_tx_seq - ack.last_acked_seq;
					seg_q <= (ack.segment_bytes == 16'd0) ? 16'd1 : ack.segment_bytes;
					slow_q <= 1'b0;
					payout_q <= 1'b0;
					pass_q <= 1'b0;
				end
			end
			ST_SR_M2: tmp_q <= prod[43:0];
			ST_RHO_W1: ms_q <= prod[48:34];
			ST_SC_W1: if (div_done) fin_q <= fin_next;
			ST_SC_W2: if (div_done) d_q <= d_next;
			ST_SC_M2: tmp_q <= prod[43:0];
			ST_SC_M3: denom_q <= denom_next;
			ST_SC_W3: if (div_done) frto_q <= div_q[15:0];
			ST_SC_W4: begin
				if (div_done) begin
					cs_q <= div_q[31:0];
					gap_hit_q <= {1'b0, gap_q} > {div_q[31:0], 1'b0};
				end
			end
			ST_SC_M6: begin
				scale2_q <= f_fl;
				if (!pass_q)
					scale1_q <= f_fl;
			end
			ST_SS_CHK: begin
				if (cwnd_q <= ssth_q)
					slow_q <= 1'b1;
				p_q <= 32'h4000_0000;
				pi_q <= 3'd0;
			end
			ST_PW_A: begin
				if (rho_lo[pi_q])
					p_q <= prod[61:30];
				pi_q <= pi_q + 3'd1;
			end
			ST_SS_PW: tmp_q <= {12'b0, pwm[31:0]};
			ST_SS_M3: begin
				cwnd_q <= (ss_sum > {1'b0, ssth_q}) ? ssth_q : ss_sum[31:0];
				segs_q <= segs_q - 16'd1;
			end
			ST_AV_CHK: begin
				if (cwnd_q >= ssth_q && segs_q != 16'd0 && slow_q)
					pass_q <= 1'b1;
			end
			ST_AV_W: if (div_done) tmp_q <= {19'b0, div_q[24:0]};
			ST_AV_A: acc_q <= acc_sat;
			ST_AV_M4: begin
				cwnd_q <= av_sum[32] ? 32'hFFFF_FFFF : av_sum[31:0];
				payout_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_cwnd_q <= cwnd_q;
					out_scale_q <= payout_q ? scale2_q : scale1_q;
					out_slow_q <= slow_q;
				end
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

	assign result.valid = out_valid_q;
	assign result.new_cwnd_bytes = out_cwnd_q;
	assign result.growth_scale = out_scale_q;
	assign result.in_slow_start = out_slow_q;

	`HCU_ASSERT_IMP(a_div_start_idle, div_req.start, !div_stat.busy)
	`HCU_ASSERT_IMP(a_rho_range, 1'b1, rho_q >= RHO_ONE && rho_q <= RHO_MAX)
	`HCU_ASSERT_IMP(a_scale_range, result.valid, result.growth_scale >= HALF_Q15 && result.growth_scale <= ONE_Q15)
	`HCU_ASSERT_NEXT(a_window_grows, out_load, result.new_cwnd_bytes >= cwnd_in_q)
endmodule

@@ src/hcu_mul.sv @@
// shared 32x32 multiplier with registered product
module hcu_mul (
	input logic clk,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic [63:0] prod
);
	always_ff @(posedge clk) begin
		prod <= {32'b0, a} * {32'b0, b};
	end
endmodule

@@ src/hcu_div.sv @@
// shared radix-2 restoring divider, one quotient bit per cycle
module hcu_div (
	input logic clk,
	input logic arst_n,
	input hcu_pkg::div_req_t req,
	output hcu_pkg::div_stat_t stat,
	output logic [hcu_pkg::DIV_W-1:0] quotient
);
	import hcu_pkg::*;

	logic busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, dq_q, dvs_q;
	logic [DIV_W+1:0] trial;
	logic ge;

	assign trial = {1'b0, rem_q, dq_q[DIV_W-1]} - {2'b0, dvs_q};
	assign ge = !trial[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend is left aligned so only its meaningful bits are iterated
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dq_q <= req.dividend << (DIV_CNT_W'(DIV_W) - req.nbits);
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], dq_q[DIV_W-1]};
			dq_q <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = dq_q;
endmodule
